[rtl/ethernet_ipv4_frame_checker_unit_defines.svh]
// assertion macros shared by the frame checker rtl
`ifndef ETHERNET_IPV4_FRAME_CHECKER_UNIT_DEFINES_SVH
`define ETHERNET_IPV4_FRAME_CHECKER_UNIT_DEFINES_SVH

`ifndef ASSERT_OFF
// same-cycle implication, checked on every clock edge out of reset
`define EIPFC_ASSERT_IMPL(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);
// next-cycle implication
`define EIPFC_ASSERT_NEXT(name, ante, cons, msg) \
   name: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);
`else
`define EIPFC_ASSERT_IMPL(name, ante, cons, msg)
`define EIPFC_ASSERT_NEXT(name, ante, cons, msg)
`endif

`endif

[rtl/eipfc_pkg.sv]
package eipfc_pkg;

   // frame length limit and counter width
   localparam int MAX_FRAME_BYTES = 2048;
   localparam int CNT_W           = $clog2(MAX_FRAME_BYTES + 1);
   localparam int FRAME_BYTES_W   = 12;

   localparam logic [15:0] SUM_ONES      = 16'hffff;
   localparam int          ETH_HDR_BYTES = 14;
   localparam int          ARP_MIN_BYTES = 28;
   localparam logic [15:0] TYPE_ARP      = 16'h0806;
   localparam logic [15:0] TYPE_IPV4     = 16'h0800;
   localparam logic [7:0]  PROTO_ICMP    = 8'd1;
   localparam logic [7:0]  PROTO_TCP     = 8'd6;

   // result status codes
   localparam logic [3:0] STATUS_ARP_OK    = 4'd0;
   localparam logic [3:0] STATUS_ARP_SHORT = 4'd1;
   localparam logic [3:0] STATUS_ICMP_OK   = 4'd2;
   localparam logic [3:0] STATUS_TCP_OK    = 4'd3;
   localparam logic [3:0] STATUS_OTHER_IP  = 4'd4;
   localparam logic [3:0] STATUS_BAD_IP    = 4'd5;
   localparam logic [3:0] STATUS_BAD_ICMP  = 4'd6;
   localparam logic [3:0] STATUS_BAD_TCP   = 4'd7;
   localparam logic [3:0] STATUS_OTHER     = 4'd8;
   localparam logic [3:0] STATUS_TRUNCATED = 4'd9;

   typedef struct packed {
      logic [7:0] frame_byte;
      logic       last_byte;
   } req_type;

   typedef struct packed {
      logic [3:0]               status;
      logic [15:0]              frame_type;
      logic [7:0]               ip_protocol;
      logic [FRAME_BYTES_W-1:0] frame_bytes;
   } rsp_type;

   // ones' complement add with end-around carry
   function automatic logic [15:0] oc_add(input logic [15:0] acc, input logic [15:0] w);
      logic [16:0] s;
      logic [16:0] f;
      s = {1'b0, acc} + {1'b0, w};
      f = {1'b0, s[15:0]} + {16'd0, s[16]};
      return f[15:0];
   endfunction

   function automatic logic sum_ok(input logic [15:0] s);
      return (s == 16'd0) || (s == SUM_ONES);
   endfunction

endpackage

[rtl/ethernet_ipv4_frame_checker_unit.sv]
// Ethernet/IPv4 frame checker: takes a frame one byte per transfer on req_ (last_byte marks
// the final byte) and returns one result per frame on rsp_ with a status code, the
// EtherType, the IPv4 protocol and the saturated byte count. ARP frames are checked for
// length, IPv4 frames for the header checksum and then the ICMP or TCP (with pseudo-header)
// checksum. One byte is taken every clock while req_stall is low; the per-byte work is a
// single ones' complement add into the running sums. A result passes three registers in
// order (snapshot register, decision stage, output register fed by the final checksum
// stage) before rsp_valid rises. req_stall rises only when all three of those registers
// are full and rsp_stall holds the output.
`include "ethernet_ipv4_frame_checker_unit_defines.svh"

module ethernet_ipv4_frame_checker_unit
   import eipfc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_payload,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_payload
);

   // which checksum the last stage still has to test
   localparam logic [1:0] KIND_NONE = 2'd0;
   localparam logic [1:0] KIND_ICMP = 2'd1;
   localparam logic [1:0] KIND_TCP  = 2'd2;

   // ---------------------------------------------------------------- per-frame state
   logic [CNT_W-1:0] cnt_ff,    cnt_in;
   logic [15:0]      type_ff,   type_in;
   logic [3:0]       hw_ff,     hw_in;
   logic [7:0]       proto_ff,  proto_in;
   logic [15:0]      total_ff,  total_in;
   logic [15:0]      hsum_ff,   hsum_in;
   logic [15:0]      psum_ff,   psum_in;
   logic [15:0]      pseudo_ff, pseudo_in;
   logic [7:0]       hold_ff,   hold_in;

   // ---------------------------------------------------------------- snapshot at last byte
   logic             f_valid_ff;
   logic [CNT_W-1:0] f_cnt_ff;
   logic [15:0]      f_type_ff;
   logic [3:0]       f_hw_ff;
   logic [7:0]       f_proto_ff;
   logic [15:0]      f_total_ff;
   logic [15:0]      f_hsum_ff;
   logic [15:0]      f_psum_ff;
   logic [15:0]      f_pseudo_ff;
   logic [7:0]       f_hold_ff;

   // ---------------------------------------------------------------- decision stage
   logic        a_valid_ff;
   logic [3:0]  a_status_ff, a_status_in;
   logic [1:0]  a_kind_ff,   a_kind_in;
   logic [15:0] a_ps_ff,     a_ps_in;
   logic [15:0] a_t1_ff,     a_t1_in;
   logic [15:0] a_plen_ff,   a_plen_in;
   logic [15:0] a_type_ff;
   logic [7:0]  a_proto_ff,  a_proto_in;
   logic [FRAME_BYTES_W-1:0] a_bytes_ff;

   // ---------------------------------------------------------------- output register
   logic    rsp_valid_ff;
   rsp_type rsp_payload_ff, rsp_payload_in;

   // ---------------------------------------------------------------- flow control
   logic rsp_go, a_ready, f_ready, req_take;

   assign rsp_go    = !rsp_valid_ff || !rsp_stall;
   assign a_ready   = !a_valid_ff || rsp_go;
   assign f_ready   = !f_valid_ff || a_ready;
   assign req_stall = !f_ready;
   assign req_take  = req_valid && !req_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_payload_ff;

   // ---------------------------------------------------------------- byte update
   logic [CNT_W-1:0] idx;      // offset into the ethernet payload
   logic [3:0]       hw_eff;   // ihl, including the byte at offset zero
   logic [5:0]       hdr_len;
   logic [15:0]      word;
   logic [7:0]       b;

   assign b       = req_payload.frame_byte;
   assign idx     = cnt_ff - CNT_W'(ETH_HDR_BYTES);
   assign hw_eff  = (idx == '0) ? b[3:0] : hw_ff;
   assign hdr_len = {hw_eff, 2'b00};
   assign word    = {hold_ff, b};

   always_comb begin
      cnt_in    = cnt_ff;
      type_in   = type_ff;
      hw_in     = hw_ff;
      proto_in  = proto_ff;
      total_in  = total_ff;
      hsum_in   = hsum_ff;
      psum_in   = psum_ff;
      pseudo_in = pseudo_ff;
      hold_in   = hold_ff;
      // bytes past the limit are neither counted nor checked
      if (cnt_ff < CNT_W'(MAX_FRAME_BYTES)) begin
         cnt_in = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(12)) begin
            type_in = {b, 8'h00};
         end else if (cnt_ff == CNT_W'(13)) begin
            type_in = {type_ff[15:8], b};
         end else if (cnt_ff >= CNT_W'(ETH_HDR_BYTES) && type_ff == TYPE_IPV4) begin
            hw_in = hw_eff;
            if (idx == CNT_W'(9)) begin
               proto_in = b;
            end
            if (idx < CNT_W'(hdr_len)) begin
               // ip header word
               if (!idx[0]) begin
                  hold_in = b;
               end else begin
                  hsum_in = oc_add(hsum_ff, word);
                  if (idx == CNT_W'(3)) begin
                     total_in = word;
                  end
                  // source and destination addresses feed the pseudo-header
                  if (idx >= CNT_W'(12) && idx <= CNT_W'(19)) begin
                     pseudo_in = oc_add(pseudo_ff, word);
                  end
               end
            end else if (16'(idx) < total_ff) begin
               // ip payload word; padding beyond total length is ignored
               if (!idx[0]) begin
                  hold_in = b;
               end else begin
                  psum_in = oc_add(psum_ff, word);
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff    <= '0;
         type_ff   <= '0;
         hw_ff     <= '0;
         proto_ff  <= '0;
         total_ff  <= '0;
         hsum_ff   <= '0;
         psum_ff   <= '0;
         pseudo_ff <= '0;
         hold_ff   <= '0;
      end else if (req_take) begin
         if (req_payload.last_byte) begin
            // every frame starts from a clean state
            cnt_ff    <= '0;
            type_ff   <= '0;
            hw_ff     <= '0;
            proto_ff  <= '0;
            total_ff  <= '0;
            hsum_ff   <= '0;
            psum_ff   <= '0;
            pseudo_ff <= '0;
            hold_ff   <= '0;
         end else begin
            cnt_ff    <= cnt_in;
            type_ff   <= type_in;
            hw_ff     <= hw_in;
            proto_ff  <= proto_in;
            total_ff  <= total_in;
            hsum_ff   <= hsum_in;
            psum_ff   <= psum_in;
            pseudo_ff <= pseudo_in;
            hold_ff   <= hold_in;
         end
      end
   end

   // snapshot of the finished frame, including its last byte
   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (req_take && req_payload.last_byte) begin
         f_valid_ff <= 1'b1;
      end else if (a_ready) begin
         f_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take && req_payload.last_byte) begin
         f_cnt_ff    <= cnt_in;
         f_type_ff   <= type_in;
         f_hw_ff     <= hw_in;
         f_proto_ff  <= proto_in;
         f_total_ff  <= total_in;
         f_hsum_ff   <= hsum_in;
         f_psum_ff   <= psum_in;
         f_pseudo_ff <= pseudo_in;
         f_hold_ff   <= hold_in;
      end
   end

   // ---------------------------------------------------------------- decision stage
   logic [CNT_W-1:0] pay;
   logic [5:0]       f_hdr;

   assign pay   = (f_cnt_ff >= CNT_W'(ETH_HDR_BYTES)) ? f_cnt_ff - CNT_W'(ETH_HDR_BYTES) : '0;
   assign f_hdr = {f_hw_ff, 2'b00};

   assign a_plen_in  = f_total_ff - 16'(f_hdr);
   // an odd payload leaves its last byte waiting for a zero low byte
   assign a_ps_in    = a_plen_in[0] ? oc_add(f_psum_ff, {f_hold_ff, 8'h00}) : f_psum_ff;
   assign a_t1_in    = oc_add(f_pseudo_ff, {8'h00, f_proto_ff});
   assign a_proto_in = (f_type_ff == TYPE_IPV4) ? f_proto_ff : 8'h00;

   always_comb begin
      a_status_in = STATUS_OTHER;
      a_kind_in   = KIND_NONE;
      if (f_cnt_ff < CNT_W'(ETH_HDR_BYTES)) begin
         a_status_in = STATUS_TRUNCATED;
      end else if (f_type_ff == TYPE_ARP) begin
         a_status_in = (pay < CNT_W'(ARP_MIN_BYTES)) ? STATUS_ARP_SHORT : STATUS_ARP_OK;
      end else if (f_type_ff == TYPE_IPV4) begin
         if (pay == '0) begin
            a_status_in = STATUS_TRUNCATED;
         end else if (f_hw_ff < 4'd5) begin
            a_status_in = STATUS_BAD_IP;
         end else if (pay < CNT_W'(f_hdr)) begin
            a_status_in = STATUS_TRUNCATED;
         end else if (!sum_ok(f_hsum_ff)) begin
            a_status_in = STATUS_BAD_IP;
         end else if (f_total_ff < 16'(f_hdr)) begin
            a_status_in = STATUS_BAD_IP;
         end else if (16'(pay) < f_total_ff) begin
            a_status_in = STATUS_TRUNCATED;
         end else if (f_proto_ff == PROTO_ICMP) begin
            a_status_in = STATUS_BAD_ICMP;
            a_kind_in   = KIND_ICMP;
         end else if (f_proto_ff == PROTO_TCP) begin
            a_status_in = STATUS_BAD_TCP;
            a_kind_in   = KIND_TCP;
         end else begin
            a_status_in = STATUS_OTHER_IP;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (a_ready) begin
         a_valid_ff <= f_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (a_ready) begin
         a_status_ff <= a_status_in;
         a_kind_ff   <= a_kind_in;
         a_ps_ff     <= a_ps_in;
         a_t1_ff     <= a_t1_in;
         a_plen_ff   <= a_plen_in;
         a_type_ff   <= f_type_ff;
         a_proto_ff  <= a_proto_in;
         a_bytes_ff  <= FRAME_BYTES_W'(f_cnt_ff);
      end
   end

   // ---------------------------------------------------------------- final checksum stage
   logic [15:0] tcp_sum;

   assign tcp_sum = oc_add(oc_add(a_t1_ff, a_plen_ff), a_ps_ff);

   always_comb begin
      rsp_payload_in.frame_type  = a_type_ff;
      rsp_payload_in.ip_protocol = a_proto_ff;
      rsp_payload_in.frame_bytes = a_bytes_ff;
      case (a_kind_ff)
         KIND_ICMP: rsp_payload_in.status = sum_ok(a_ps_ff) ? STATUS_ICMP_OK : a_status_ff;
         KIND_TCP:  rsp_payload_in.status = sum_ok(tcp_sum) ? STATUS_TCP_OK : a_status_ff;
         default:   rsp_payload_in.status = a_status_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (rsp_go) begin
         rsp_valid_ff <= a_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_go) begin
         rsp_payload_ff <= rsp_payload_in;
      end
   end

   // ---------------------------------------------------------------- assertions
   logic last_take;   // last byte of a frame transferred
   logic f_stuck;     // finished frame waiting on the decision stage
   logic rsp_not_ip;  // result of a frame that is not ipv4

   assign last_take  = req_take && req_payload.last_byte;
   assign f_stuck    = f_valid_ff && !a_ready;
   assign rsp_not_ip = rsp_valid_ff && (rsp_payload_ff.frame_type != TYPE_IPV4);

   `EIPFC_ASSERT_NEXT(a_clear_after_last, last_take, cnt_ff == '0, "count not cleared")
   `EIPFC_ASSERT_IMPL(a_count_saturates, 1'b1, cnt_ff <= CNT_W'(MAX_FRAME_BYTES), "count high")
   `EIPFC_ASSERT_NEXT(a_snapshot_held, f_stuck, f_valid_ff && $stable(f_cnt_ff), "frame lost")
   `EIPFC_ASSERT_IMPL(a_proto_ipv4, rsp_not_ip, rsp_payload.ip_protocol == 8'h00, "non-ip proto")
   `EIPFC_ASSERT_IMPL(a_status_range, rsp_valid, rsp_payload.status <= STATUS_TRUNCATED, "status")

endmodule

[tb/ethernet_ipv4_frame_checker_unit_test.sv]
module ethernet_ipv4_frame_checker_unit_test;
   import eipfc_pkg::*;

   // generous bound on the whole run, far above the slowest legal schedule
   localparam int CYCLE_LIMIT = 400000;
   // receiver hold-off used to back up the whole pipeline
   localparam int LONG_HOLD_CYCLES = 400;

   // dut signals; the driven inputs are known from time zero
   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_payload;

   // traffic shaping knobs, changed only between phases
   int send_idle_pct = 0;
   int stall_pct = 0;
   bit long_hold_req = 1'b0;

   // receiver hold-off bookkeeping, owned by the receiver process
   int hold_left = 0;
   bit hold_done = 1'b0;

   // stimulus and expectation stores
   req_type    frame_byte_queue[$];
   rsp_type    expected_verdicts[$];
   logic [7:0] frame_buf[$];

   // run statistics
   int          cycle_count = 0;
   int          bytes_queued = 0;
   int          frames_queued = 0;
   int          verdicts_checked = 0;
   int          mismatch_count = 0;
   logic [15:0] status_seen = '0;

   // predictor state for the frame in progress
   int          fc_count = 0;
   logic [15:0] fc_type = '0;
   logic [3:0]  fc_ihl = '0;
   logic [7:0]  fc_proto = '0;
   logic [15:0] fc_total = '0;
   logic [15:0] fc_hsum = '0;
   logic [15:0] fc_psum = '0;
   logic [15:0] fc_pseudo = '0;
   logic [7:0]  fc_hold = '0;

   ethernet_ipv4_frame_checker_unit u_top (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload)
   );

   initial begin
      forever #10 clock = ~clock;
   end

   // ones' complement add, end-around carry folded back in
   function automatic logic [15:0] ones_add(input logic [15:0] a, input logic [15:0] b);
      logic [16:0] s;
      s = {1'b0, a} + {1'b0, b};
      return s[15:0] + {15'd0, s[16]};
   endfunction

   // both zero encodings count as a good folded sum
   function automatic bit sum_valid(input logic [15:0] s);
      return (s == 16'h0000) || (s == 16'hffff);
   endfunction

   // predictor: absorbs one accepted byte, queues a verdict on the last one
   task automatic predict_frame_byte(input req_type item);
      rsp_type     verdict;
      int          idx;
      int          hdr;
      int          pay;
      logic [15:0] word;
      logic [15:0] ps;
      logic [15:0] tot;
      logic [15:0] plen;
      // bytes past the length cap are neither counted nor summed
      if (fc_count < MAX_FRAME_BYTES) begin
         if (fc_count == 12) begin
            fc_type = {item.frame_byte, 8'h00};
         end else if (fc_count == 13) begin
            fc_type[7:0] = item.frame_byte;
         end else if (fc_count >= ETH_HDR_BYTES && fc_type == TYPE_IPV4) begin
            idx = fc_count - ETH_HDR_BYTES;
            if (idx == 0) fc_ihl = item.frame_byte[3:0];
            if (idx == 9) fc_proto = item.frame_byte;
            hdr = int'(fc_ihl) * 4;
            // header words first, then payload words up to the total length
            if (idx < hdr || idx < int'(fc_total)) begin
               if (idx % 2 == 0) begin
                  fc_hold = item.frame_byte;
               end else begin
                  word = {fc_hold, item.frame_byte};
                  if (idx < hdr) begin
                     fc_hsum = ones_add(fc_hsum, word);
                     if (idx == 3) fc_total = word;
                     // source and destination addresses feed the tcp pseudo-header
                     if (idx >= 12 && idx <= 19) fc_pseudo = ones_add(fc_pseudo, word);
                  end else begin
                     fc_psum = ones_add(fc_psum, word);
                  end
               end
            end
         end
         fc_count++;
      end
      if (item.last_byte) begin
         pay = (fc_count >= ETH_HDR_BYTES) ? fc_count - ETH_HDR_BYTES : 0;
         hdr = int'(fc_ihl) * 4;
         verdict.frame_type  = fc_type;
         verdict.ip_protocol = 8'h00;
         verdict.frame_bytes = FRAME_BYTES_W'(fc_count);
         if (fc_count < ETH_HDR_BYTES) begin
            verdict.status = STATUS_TRUNCATED;
         end else if (fc_type == TYPE_ARP) begin
            verdict.status = (pay < ARP_MIN_BYTES) ? STATUS_ARP_SHORT : STATUS_ARP_OK;
         end else if (fc_type != TYPE_IPV4) begin
            verdict.status = STATUS_OTHER;
         end else begin
            verdict.ip_protocol = fc_proto;
            plen = fc_total - 16'(hdr);
            // odd payload: trailing byte padded with a zero low byte
            ps = fc_psum;
            if (plen[0]) ps = ones_add(ps, {fc_hold, 8'h00});
            tot = ones_add(ones_add(ones_add(fc_pseudo, {8'h00, fc_proto}), plen), ps);
            if (pay == 0) begin
               verdict.status = STATUS_TRUNCATED;
            end else if (fc_ihl < 5) begin
               verdict.status = STATUS_BAD_IP;
            end else if (pay < hdr) begin
               verdict.status = STATUS_TRUNCATED;
            end else if (!sum_valid(fc_hsum) || int'(fc_total) < hdr) begin
               verdict.status = STATUS_BAD_IP;
            end else if (pay < int'(fc_total)) begin
               verdict.status = STATUS_TRUNCATED;
            end else if (fc_proto == PROTO_ICMP) begin
               verdict.status = sum_valid(ps) ? STATUS_ICMP_OK : STATUS_BAD_ICMP;
            end else if (fc_proto == PROTO_TCP) begin
               verdict.status = sum_valid(tot) ? STATUS_TCP_OK : STATUS_BAD_TCP;
            end else begin
               verdict.status = STATUS_OTHER_IP;
            end
         end
         expected_verdicts.push_back(verdict);
         // every frame starts from a clean slate
         fc_count  = 0;
         fc_type   = '0;
         fc_ihl    = '0;
         fc_proto  = '0;
         fc_total  = '0;
         fc_hsum   = '0;
         fc_psum   = '0;
         fc_pseudo = '0;
         fc_hold   = '0;
      end
   endtask

   // frame construction helpers working on frame_buf
   task automatic pad_random(input int n);
      repeat (n) frame_buf.push_back(8'($urandom));
   endtask

   task automatic start_frame(input logic [15:0] ether);
      frame_buf.delete();
      pad_random(12);
      frame_buf.push_back(ether[15:8]);
      frame_buf.push_back(ether[7:0]);
   endtask

   task automatic trim_frame(input int keep);
      while (frame_buf.size() > keep) void'(frame_buf.pop_back());
   endtask

   // big-endian word sum over a byte span, odd tail padded with zero
   function automatic logic [15:0] sum_bytes(input int first, input int count);
      logic [15:0] acc;
      int          k;
      acc = '0;
      for (k = 0; k < count; k += 2) begin
         acc = ones_add(acc, {frame_buf[first + k],
                              (k + 1 < count) ? frame_buf[first + k + 1] : 8'h00});
      end
      return acc;
   endfunction

   // well-formed ipv4 frame with valid sums; tot_len < 0 keeps the natural length
   task automatic build_ipv4(input logic [7:0] proto, input logic [3:0] ihl,
                             input int plen, input int tot_len);
      int          hl;
      int          pos;
      int          off;
      logic [15:0] tl;
      logic [15:0] s;
      hl = (ihl < 5) ? 20 : int'(ihl) * 4;
      tl = (tot_len < 0) ? 16'(int'(ihl) * 4 + plen) : 16'(tot_len);
      start_frame(TYPE_IPV4);
      pad_random(hl);
      frame_buf[14]      = {4'h4, ihl};
      frame_buf[14 + 2]  = tl[15:8];
      frame_buf[14 + 3]  = tl[7:0];
      frame_buf[14 + 9]  = proto;
      frame_buf[14 + 10] = 8'h00;
      frame_buf[14 + 11] = 8'h00;
      s = ~sum_bytes(14, hl);
      frame_buf[14 + 10] = s[15:8];
      frame_buf[14 + 11] = s[7:0];
      pos = 14 + hl;
      pad_random(plen);
      // payload checksum word needs two bytes to land in
      if (plen >= 2) begin
         off = (proto == PROTO_TCP && plen >= 18) ? 16 : ((plen >= 4) ? 2 : 0);
         frame_buf[pos + off]     = 8'h00;
         frame_buf[pos + off + 1] = 8'h00;
         s = sum_bytes(pos, plen);
         if (proto == PROTO_TCP) begin
            s = ones_add(s, sum_bytes(14 + 12, 8));
            s = ones_add(s, {8'h00, proto});
            s = ones_add(s, 16'(plen));
         end
         s = ~s;
         frame_buf[pos + off]     = s[15:8];
         frame_buf[pos + off + 1] = s[7:0];
      end
   endtask

   // hand the built frame to the driver, last flag on its final byte
   task automatic push_frame();
      req_type item;
      int      k;
      for (k = 0; k < frame_buf.size(); k++) begin
         item.frame_byte = frame_buf[k];
         item.last_byte  = (k == frame_buf.size() - 1);
         frame_byte_queue.push_back(item);
      end
      bytes_queued += frame_buf.size();
      frames_queued++;
   endtask

   // mostly well-formed ipv4 traffic with random content, plus damage and noise
   task automatic add_random_frames(input int min_bytes, input int min_frames);
      int         start_bytes;
      int         made;
      int         pick;
      int         plen;
      int         idx;
      logic [7:0] proto;
      logic [3:0] ihl;
      start_bytes = bytes_queued;
      made = 0;
      while (bytes_queued - start_bytes < min_bytes || made < min_frames) begin
         pick = $urandom_range(99);
         if (pick < 60) begin
            pick  = $urandom_range(99);
            proto = (pick < 40) ? PROTO_ICMP : ((pick < 80) ? PROTO_TCP : 8'($urandom));
            ihl   = ($urandom_range(4) == 0) ? 4'($urandom_range(15, 6)) : 4'd5;
            plen  = ($urandom_range(19) == 0) ? $urandom_range(200) : $urandom_range(40);
            build_ipv4(proto, ihl, plen,
                       ($urandom_range(9) == 0) ? int'($urandom_range(65535)) : -1);
            case ($urandom_range(9))
               0: begin
                  // single bit error somewhere past the ethernet header
                  idx = $urandom_range(frame_buf.size() - 1, 14);
                  frame_buf[idx] = frame_buf[idx] ^ (8'h01 << $urandom_range(7));
               end
               1: trim_frame($urandom_range(frame_buf.size() - 1, 1));
               2: pad_random($urandom_range(10, 1));
               3: frame_buf[14] = (frame_buf[14] & 8'hf0) | 8'($urandom_range(4));
               default: ;
            endcase
         end else if (pick < 75) begin
            start_frame(TYPE_ARP);
            pad_random($urandom_range(40));
         end else if (pick < 85) begin
            start_frame(16'($urandom));
            pad_random($urandom_range(60));
         end else begin
            // raw noise, often shorter than an ethernet header
            frame_buf.delete();
            pad_random($urandom_range(40, 1));
         end
         push_frame();
         made++;
      end
   endtask

   // idle until every queued byte is taken and every verdict has come back
   task automatic wait_drained();
      while (frame_byte_queue.size() != 0 || req_valid || expected_verdicts.size() != 0)
         @(negedge clock);
   endtask

   // driver: one byte offered at a time, held steady while stalled
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && !req_stall) predict_frame_byte(req_payload);
         if (!req_valid || !req_stall) begin
            if (frame_byte_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_payload <= frame_byte_queue.pop_front();
               req_valid   <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   // receiver backpressure: random stalls plus one long hold-off on request
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (long_hold_req && !hold_done) begin
         rsp_stall <= 1'b1;
         hold_left <= LONG_HOLD_CYCLES;
         hold_done <= 1'b1;
      end else begin
         rsp_stall <= ($urandom_range(99) < stall_pct);
      end
   end

   function automatic void check_field(input string what, input int want, input int got);
      if (want != got) begin
         $display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h", $time, what, want, got);
         mismatch_count++;
      end
   endfunction

   // monitor: every result transfer is matched against the oldest verdict
   always @(posedge clock) begin
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_verdicts.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual %p", $time, rsp_payload);
            mismatch_count++;
         end else begin
            want = expected_verdicts.pop_front();
            check_field("status", int'(want.status), int'(rsp_payload.status));
            check_field("frame_type", int'(want.frame_type), int'(rsp_payload.frame_type));
            check_field("ip_protocol", int'(want.ip_protocol), int'(rsp_payload.ip_protocol));
            check_field("frame_bytes", int'(want.frame_bytes), int'(rsp_payload.frame_bytes));
            status_seen[want.status] <= 1'b1;
            verdicts_checked++;
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("CHECK FAILED");
         $finish;
      end
   end

   initial begin
      // synchronous reset held from time zero, then released once
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // directed cases, no idling on either side
      frame_buf.delete();
      frame_buf.push_back(8'hff);
      push_frame();                                       // single-byte frame
      frame_buf.delete();
      pad_random(13);
      push_frame();                                       // one byte short of a header
      start_frame(TYPE_ARP);
      pad_random(ARP_MIN_BYTES);
      push_frame();                                       // arp at minimum length
      start_frame(TYPE_ARP);
      pad_random(ARP_MIN_BYTES - 1);
      push_frame();                                       // arp one byte short
      start_frame(16'h86dd);
      pad_random(30);
      push_frame();                                       // non-ip ethertype
      frame_buf.delete();
      repeat (40) frame_buf.push_back(8'hff);
      push_frame();                                       // all ones
      frame_buf.delete();
      repeat (20) frame_buf.push_back(8'h00);
      push_frame();                                       // all zeros
      start_frame(TYPE_IPV4);
      push_frame();                                       // ipv4 with empty payload
      build_ipv4(PROTO_ICMP, 4'd5, 8, -1);
      push_frame();                                       // good icmp
      build_ipv4(PROTO_ICMP, 4'd5, 9, -1);
      push_frame();                                       // good icmp, odd length
      build_ipv4(PROTO_ICMP, 4'd5, 12, -1);
      frame_buf[14 + 20 + 5] = frame_buf[14 + 20 + 5] ^ 8'h10;
      push_frame();                                       // bad icmp sum
      build_ipv4(PROTO_TCP, 4'd5, 20, -1);
      push_frame();                                       // good tcp
      build_ipv4(PROTO_TCP, 4'd15, 21, -1);
      push_frame();                                       // widest header, odd tcp length
      build_ipv4(PROTO_TCP, 4'd5, 24, -1);
      frame_buf[frame_buf.size() - 1] = frame_buf[frame_buf.size() - 1] ^ 8'h01;
      push_frame();                                       // bad tcp sum
      build_ipv4(8'd17, 4'd5, 16, -1);
      push_frame();                                       // other ip protocol
      build_ipv4(PROTO_ICMP, 4'd4, 8, -1);
      push_frame();                                       // header length below minimum
      build_ipv4(PROTO_ICMP, 4'd0, 8, -1);
      push_frame();                                       // header length zero
      build_ipv4(PROTO_TCP, 4'd5, 0, -1);
      trim_frame(14 + 10);
      push_frame();                                       // header cut off
      build_ipv4(PROTO_ICMP, 4'd5, 5, -1);
      trim_frame(14 + 5);
      push_frame();                                       // protocol byte never arrives
      build_ipv4(PROTO_ICMP, 4'd5, 8, -1);
      frame_buf[14 + 8] = frame_buf[14 + 8] ^ 8'h01;
      push_frame();                                       // bad header sum
      build_ipv4(PROTO_ICMP, 4'd5, 8, 12);
      push_frame();                                       // total length below header
      build_ipv4(PROTO_TCP, 4'd5, 40, -1);
      trim_frame(14 + 20 + 30);
      push_frame();                                       // frame cut off before total length
      build_ipv4(PROTO_ICMP, 4'd5, 10, -1);
      pad_random(12);
      push_frame();                                       // trailing pad ignored
      wait_drained();

      // no idling, but the receiver holds off long enough to back up the input
      long_hold_req = 1'b1;
      add_random_frames(130, 5);
      wait_drained();

      // sender gaps only
      send_idle_pct = 52;
      add_random_frames(100, 3);
      wait_drained();

      // receiver stalls only
      send_idle_pct = 0;
      stall_pct = 52;
      add_random_frames(100, 3);
      wait_drained();

      // both sides idle
      send_idle_pct = 38;
      stall_pct = 38;
      add_random_frames(100, 3);
      wait_drained();

      // watch a few more cycles for stray results past the pipeline depth
      repeat (10) @(negedge clock);
      $display("covered %0d frames (%0d bytes), %0d results compared, status mask 0x%0h",
               frames_queued, bytes_queued, verdicts_checked, status_seen);
      $display("phases: directed, long output hold, input gaps, output stalls, mixed");
      if (mismatch_count == 0 && expected_verdicts.size() == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

endmodule
